// File: rtl/breakpoint_address_table_unit_macros.svh
// Assertion macros for the breakpoint address table RTL.
// Each macro expands to one clocked, reset-qualified concurrent assertion.
`ifndef BREAKPOINT_ADDRESS_TABLE_UNIT_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define BAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bat_pkg.sv
// Package for the breakpoint address table: operation codes, status codes,
// result field types and the lookup summary struct. No dependencies.
package bat_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_DELETE   = 3'd1,
    OP_CHECK    = 3'd2,
    OP_SET_TEMP = 3'd3,
    OP_ARRIVE   = 3'd4,
    OP_LIST     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADD_FULL = 2'd1,
    ST_DEL_NONE = 2'd2
  } status_e;

  // Breakpoint addresses are 16 bits wide.
  typedef logic [15:0] addr_t;

  // Slot number as reported on the result port.
  typedef logic [3:0] slot_field_t;

  // Slot index wide enough for the largest supported table of 64 slots.
  typedef logic [5:0] lk_idx_t;

  // Summary of comparing one address against the whole table.
  typedef struct packed {
    logic    add_found;
    lk_idx_t add_slot;
    logic    del_found;
    lk_idx_t del_slot;
    logic    hit;
    logic    arrive_hit;
  } lookup_t;

endpackage

// File: rtl/bat_lookup.sv
// Parallel comparators and first-match selection for the breakpoint table.
// Depends on bat_pkg.
module bat_lookup #(
  parameter int SLOTS = 11
) (
  input  bat_pkg::addr_t   address,
  input  logic [SLOTS-1:0] slot_valid,
  input  bat_pkg::addr_t   slot_address [SLOTS],
  output bat_pkg::lookup_t result
);

  logic [SLOTS-1:0] eq;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      eq[j] = (slot_address[j] == address);
    end
  end

  // Scanning from the top down leaves the lowest qualifying slot selected.
  always_comb begin
    result            = '0;
    result.hit        = |(slot_valid & eq);
    result.arrive_hit = slot_valid[0] & eq[0];
    for (int j = SLOTS - 1; j >= 1; j--) begin
      if (!slot_valid[j] || eq[j]) begin
        result.add_found = 1'b1;
        result.add_slot  = bat_pkg::lk_idx_t'(j);
      end
    end
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (eq[j]) begin
        result.del_found = 1'b1;
        result.del_slot  = bat_pkg::lk_idx_t'(j);
      end
    end
  end

endmodule

// File: rtl/breakpoint_address_table_unit.sv
// Breakpoint address table: the top level, built on bat_lookup and bat_pkg.
// A request's first result is loaded into the output register when the request is accepted.
// Throughput: one request per cycle while the result channel is not stalled; a list request
// with N set slots gives N results and holds off new requests until its last is registered.
// Reset (synchronous, rst_n low) clears every valid bit and stored address at once.
module breakpoint_address_table_unit #(
  parameter int SLOTS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_op,
  input  logic [15:0]           in_address,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [1:0]            out_status,
  output logic [3:0]            out_slot,
  output logic [15:0]           out_entry_address,
  output logic                  out_entry_present,
  output logic                  out_any_set,
  output logic                  out_last
);

`include "breakpoint_address_table_unit_macros.svh"

  localparam int IdxW = $clog2(SLOTS);

  // The table itself. With at most 64 slots it lives in flip-flops, so
  // reset can clear it all at once and every slot has its own comparator.
  logic [SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  bat_pkg::addr_t   slot_addr_r [SLOTS];

  // Slots still to be reported by a list request in progress.
  logic [SLOTS-1:0] list_mask_r, list_mask_nxt;

  // Output register.
  logic                  out_valid_r;
  logic                  hit_r, hit_nxt;
  bat_pkg::status_e      status_r, status_nxt;
  bat_pkg::slot_field_t  slot_r, slot_nxt;
  bat_pkg::addr_t        entry_addr_r, entry_addr_nxt;
  logic                  present_r, present_nxt;
  logic                  any_set_r;
  logic                  last_r, last_nxt;

  logic             listing;
  logic             load_ok;
  logic             accept;
  logic             list_step;
  logic             out_load;
  logic             addr_we;
  logic [IdxW-1:0]  addr_widx;

  logic [SLOTS-1:0] list_src;
  logic [SLOTS-1:0] list_low;
  logic [SLOTS-1:0] list_rest;
  logic [IdxW-1:0]  pick_idx;
  logic             pick_any;

  bat_pkg::lookup_t lk;
  logic [IdxW-1:0]  add_idx;
  logic [IdxW-1:0]  del_idx;

  // Handshake. The output register can take a new result when it is empty
  // or its current result leaves in this cycle. While a list request is
  // still walking the table, new requests are held off.
  assign listing   = |list_mask_r;
  assign load_ok   = !out_valid_r || !out_stall;
  assign in_stall  = listing || !load_ok;
  assign accept    = in_valid && !in_stall;
  assign list_step = listing && load_ok;

  bat_lookup #(
    .SLOTS (SLOTS)
  ) u_lookup (
    .address      (in_address),
    .slot_valid   (slot_valid_r),
    .slot_address (slot_addr_r),
    .result       (lk)
  );

  assign add_idx = lk.add_slot[IdxW-1:0];
  assign del_idx = lk.del_slot[IdxW-1:0];

  // List walk. A fresh list request starts from the valid bits; later steps
  // continue from the remaining mask. Each step isolates the lowest set bit
  // and reports that slot, so slots come out in ascending order.
  assign list_src  = listing ? list_mask_r : slot_valid_r;
  assign list_low  = list_src & (~list_src + {{(SLOTS-1){1'b0}}, 1'b1});
  assign list_rest = list_src & ~list_low;
  assign pick_any  = |list_src;

  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (list_low[j]) begin
        pick_idx = pick_idx | IdxW'(j);
      end
    end
  end

  // Operation decode: next table state and the next result.
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    list_mask_nxt  = list_mask_r;
    addr_we        = 1'b0;
    addr_widx      = '0;
    out_load       = 1'b0;
    hit_nxt        = 1'b0;
    status_nxt     = bat_pkg::ST_OK;
    slot_nxt       = '0;
    entry_addr_nxt = '0;
    present_nxt    = 1'b0;
    last_nxt       = 1'b1;
    if (list_step) begin
      out_load       = 1'b1;
      slot_nxt       = bat_pkg::slot_field_t'(pick_idx);
      entry_addr_nxt = slot_addr_r[pick_idx];
      present_nxt    = 1'b1;
      last_nxt       = (list_rest == '0);
      list_mask_nxt  = list_rest;
    end else if (accept) begin
      out_load = 1'b1;
      unique case (bat_pkg::op_e'(in_op))
        bat_pkg::OP_ADD: begin
          if (lk.add_found) begin
            slot_valid_nxt[add_idx] = 1'b1;
            addr_we                 = 1'b1;
            addr_widx               = add_idx;
            slot_nxt                = bat_pkg::slot_field_t'(add_idx);
          end else begin
            status_nxt = bat_pkg::ST_ADD_FULL;
          end
        end
        bat_pkg::OP_DELETE: begin
          // The stored address decides, set or not.
          if (lk.del_found) begin
            slot_valid_nxt[del_idx] = 1'b0;
            slot_nxt                = bat_pkg::slot_field_t'(del_idx);
          end else begin
            status_nxt = bat_pkg::ST_DEL_NONE;
          end
        end
        bat_pkg::OP_CHECK: begin
          hit_nxt = lk.hit;
        end
        bat_pkg::OP_SET_TEMP: begin
          slot_valid_nxt[0] = 1'b1;
          addr_we           = 1'b1;
          addr_widx         = '0;
        end
        bat_pkg::OP_ARRIVE: begin
          if (lk.arrive_hit) begin
            slot_valid_nxt[0] = 1'b0;
            hit_nxt           = 1'b1;
          end
        end
        bat_pkg::OP_LIST: begin
          // An empty table gives one result with entry_present low.
          if (pick_any) begin
            slot_nxt       = bat_pkg::slot_field_t'(pick_idx);
            entry_addr_nxt = slot_addr_r[pick_idx];
            present_nxt    = 1'b1;
            last_nxt       = (list_rest == '0);
            list_mask_nxt  = list_rest;
          end
        end
        default: begin
          // Unused operation codes leave the table alone.
        end
      endcase
    end
  end

  // Table state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      list_mask_r  <= '0;
      for (int j = 0; j < SLOTS; j++) begin
        slot_addr_r[j] <= '0;
      end
    end else begin
      slot_valid_r <= slot_valid_nxt;
      list_mask_r  <= list_mask_nxt;
      if (addr_we) begin
        slot_addr_r[addr_widx] <= in_address;
      end
    end
  end

  // Output register: valid is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit_r        <= hit_nxt;
      status_r     <= status_nxt;
      slot_r       <= slot_nxt;
      entry_addr_r <= entry_addr_nxt;
      present_r    <= present_nxt;
      any_set_r    <= |slot_valid_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_entry_address = entry_addr_r;
  assign out_entry_present = present_r;
  assign out_any_set       = any_set_r;
  assign out_last          = last_r;

  // A list walk only visits slots that are set.
  `BAT_ASSERT_NOW(a_list_subset, clk, rst_n, 1'b1, (list_mask_r & ~slot_valid_r) == '0,
                  "list walk holds a slot that is not set")
  // The table does not change while a list walk is in progress.
  `BAT_ASSERT_NEXT(a_list_frozen, clk, rst_n, listing, $stable(slot_valid_r),
                   "table changed during a list walk")
  // A result that is not the last of its request must be followed by more.
  `BAT_ASSERT_NEXT(a_more_follows, clk, rst_n, out_load && !last_nxt, listing,
                   "non-final result without a list walk behind it")
  // The registered any_set flag tracks the table until the next request.
  `BAT_ASSERT_NOW(a_any_set, clk, rst_n, out_valid_r, any_set_r == (|slot_valid_r),
                  "any_set disagrees with the table")

endmodule
